[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

[hw/rtl/isc_pkg.sv]
// Types and codes for the induced subgraph connectivity block.
package isc_pkg;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 8;

    localparam int ROW_LSB = 0;
    localparam int COL_LSB = 6;
    localparam int NEG_BIT = 12;
    localparam int SET_LSB = 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENT_A,
        S_ENT_B,
        S_SCAN,
        S_EMIT
    } isc_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } isc_cmd_t;

endpackage

[hw/rtl/isc_ram.sv]
// Generic simple dual-port RAM with registered read.
module isc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/isc_adj_store.sv]
// Adjacency row store: RAM plus per-row valid bits for instant clear.
`include "assert_macros.svh"
module isc_adj_store import isc_pkg::*; #(
    parameter int VERTICES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  isc_cmd_t                    cmd,
    input  logic [$clog2(VERTICES)-1:0] raddr,
    input  logic [$clog2(VERTICES)-1:0] waddr,
    input  logic [VERTICES-1:0]         wdata,
    output logic [VERTICES-1:0]         rdata
);

    logic [VERTICES-1:0] valid_reg;
    logic [VERTICES-1:0] valid_next;
    logic                rd_ok_reg;
    logic [VERTICES-1:0] ram_q;

    isc_ram #(
        .WIDTH (VERTICES),
        .DEPTH (VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (cmd.wr_en)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.rd_en)
            begin
                rd_ok_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_ok_reg ? ram_q : '0;

    `ASSERT_NEVER(a_rw_same_row, clk, rst_n,
        cmd.rd_en && cmd.wr_en && (raddr == waddr), "read and write hit the same row")
    `ASSERT_NEVER(a_clear_alone, clk, rst_n,
        cmd.clear && (cmd.rd_en || cmd.wr_en), "clear overlaps a row access")
    `ASSERT_PROP(a_wr_sets_valid, clk, rst_n,
        (cmd.wr_en && !cmd.clear) |=> valid_reg[$past(waddr)], "written row not marked valid")

endmodule

[hw/rtl/induced_subgraph_connectivity.sv]
// A negative entry updates its two rows in S_ENT_A and S_ENT_B. A query on at most one
// vertex, or with the all-negative flag set, goes straight to S_EMIT; others scan level
// by level in S_SCAN, one row read at a time through the single RAM read port.
// One item is worked at a time; a finished result waits in the output register.
// Reset is asynchronous: control state and row valid bits clear at once, so the
// adjacency reads as empty immediately and the all-negative flag is set.
`include "assert_macros.svh"
module induced_subgraph_connectivity import isc_pkg::*; #(
    parameter int VERTICES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row_index[5:0], column_index[11:6], entry_negative[12], vertex_set[76:13], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // connected[0], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(VERTICES);

    isc_state_t          state_reg, state_next;
    logic [AW-1:0]       row_reg, row_next;
    logic [AW-1:0]       col_reg, col_next;
    logic [VERTICES-1:0] unreached_reg, unreached_next;
    logic [VERTICES-1:0] pending_reg, pending_next;
    logic [VERTICES-1:0] acc_reg, acc_next;
    logic                rd_live_reg, rd_live_next;
    logic                result_reg, result_next;
    logic                all_neg_reg, all_neg_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_data_reg, out_data_next;

    isc_cmd_t            cmd;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic [VERTICES-1:0] wdata;
    logic [VERTICES-1:0] rdata;

    logic [5:0]          in_row;
    logic [5:0]          in_col;
    logic                in_neg;
    logic [VERTICES-1:0] in_set;
    logic                accept;
    logic                entry_ok;
    logic [VERTICES-1:0] root_oh;
    logic                quick;
    logic [VERTICES-1:0] pick;
    logic [VERTICES-1:0] acc_now;
    logic [VERTICES-1:0] level;
    logic [VERTICES-1:0] unr_left;
    logic [VERTICES-1:0] one_v;

    function automatic logic [AW-1:0] encode(input logic [VERTICES-1:0] oh);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < VERTICES; i++)
        begin
            if (oh[i])
            begin
                idx = idx | AW'(i);
            end
        end
        return idx;
    endfunction

    assign in_row = s_axis_tdata[ROW_LSB +: 6];
    assign in_col = s_axis_tdata[COL_LSB +: 6];
    assign in_neg = s_axis_tdata[NEG_BIT];
    assign in_set = s_axis_tdata[SET_LSB +: VERTICES];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign entry_ok      = (32'(in_row) < VERTICES) && (32'(in_col) < VERTICES)
                           && (in_row != in_col);
    assign root_oh       = in_set & (~in_set + 1'b1);
    assign quick         = all_neg_reg || ((in_set & (in_set - 1'b1)) == '0);
    assign pick          = pending_reg & (~pending_reg + 1'b1);
    assign acc_now       = acc_reg | (rd_live_reg ? rdata : '0);
    assign level         = acc_now & unreached_reg;
    assign unr_left      = unreached_reg & ~level;
    assign one_v         = {{(VERTICES-1){1'b0}}, 1'b1};

    isc_adj_store #(
        .VERTICES (VERTICES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .raddr (raddr),
        .waddr (waddr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        unreached_next = unreached_reg;
        pending_next   = pending_reg;
        acc_next       = acc_reg;
        rd_live_next   = 1'b0;
        result_next    = result_reg;
        all_neg_next   = all_neg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        cmd            = '0;
        raddr          = '0;
        waddr          = '0;
        wdata          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        KIND_CLEAR:
                        begin
                            cmd.clear    = 1'b1;
                            all_neg_next = 1'b1;
                        end
                        KIND_ENTRY:
                        begin
                            if (entry_ok)
                            begin
                                if (in_neg)
                                begin
                                    row_next   = in_row[AW-1:0];
                                    col_next   = in_col[AW-1:0];
                                    cmd.rd_en  = 1'b1;
                                    raddr      = in_row[AW-1:0];
                                    state_next = S_ENT_A;
                                end
                                else
                                begin
                                    all_neg_next = 1'b0;
                                end
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (quick)
                            begin
                                result_next = 1'b1;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                unreached_next = in_set & ~root_oh;
                                pending_next   = root_oh;
                                acc_next       = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ENT_A:
            begin
                cmd.wr_en  = 1'b1;
                waddr      = row_reg;
                wdata      = rdata | (one_v << col_reg);
                cmd.rd_en  = 1'b1;
                raddr      = col_reg;
                state_next = S_ENT_B;
            end
            S_ENT_B:
            begin
                cmd.wr_en  = 1'b1;
                waddr      = col_reg;
                wdata      = rdata | (one_v << row_reg);
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (pending_reg != '0)
                begin
                    cmd.rd_en    = 1'b1;
                    raddr        = encode(pick);
                    pending_next = pending_reg & ~pick;
                    rd_live_next = 1'b1;
                    acc_next     = acc_now;
                end
                else if (level == '0)
                begin
                    result_next = 1'b0;
                    state_next  = S_EMIT;
                end
                else if (unr_left == '0)
                begin
                    result_next = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    unreached_next = unr_left;
                    pending_next   = level;
                    acc_next       = '0;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_live_reg   <= 1'b0;
            all_neg_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            unreached_reg <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_live_reg   <= rd_live_next;
            all_neg_reg   <= all_neg_next;
            out_valid_reg <= out_valid_next;
            unreached_reg <= unreached_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        acc_reg      <= acc_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_data_reg};

    `ASSERT_PROP(a_frontier_disjoint, clk, rst_n, (state_reg == S_SCAN) |-> ((unreached_reg & pending_reg) == '0), "frontier overlaps unreached set")
    `ASSERT_PROP(a_out_from_emit, clk, rst_n, $rose(m_axis_tvalid) |-> ($past(state_reg) == S_EMIT), "result raised outside emit")
    `ASSERT_PROP(a_live_from_scan, clk, rst_n, rd_live_reg |-> ($past(state_reg) == S_SCAN), "row data pending outside scan")

endmodule

[tb/sv/tb.sv]
// Scoreboard-based regression for the induced subgraph connectivity block.
`timescale 1ns / 100ps

import isc_pkg::*;

class connectivity_scoreboard;
    logic [63:0] adjacency_rows [64];
    bit          negative_only;
    bit          answers_due [$];
    int          mismatches;
    int          answers_checked;
    int          answers_connected;

    function new();
        wipe_graph();
        mismatches        = 0;
        answers_checked   = 0;
        answers_connected = 0;
    endfunction

    function void wipe_graph();
        foreach (adjacency_rows[i])
        begin
            adjacency_rows[i] = '0;
        end
        negative_only = 1'b1;
    endfunction

    // level-by-level reachability from the lowest vertex of the set
    function bit set_is_connected(logic [63:0] vset);
        logic [63:0] unreached;
        logic [63:0] frontier;
        logic [63:0] reached_now;
        int          root;
        if (negative_only || vset == '0)
        begin
            return 1'b1;
        end
        root = 0;
        while (!vset[root])
        begin
            root++;
        end
        unreached = vset & ~(64'd1 << root);
        if (unreached == '0)
        begin
            return 1'b1;
        end
        if ((unreached & ~adjacency_rows[root]) == '0)
        begin
            return 1'b1;
        end
        frontier = 64'd1 << root;
        while (unreached != '0)
        begin
            reached_now = '0;
            for (int v = 0; v < 64; v++)
            begin
                if (frontier[v])
                begin
                    reached_now |= adjacency_rows[v];
                end
            end
            reached_now &= unreached;
            if (reached_now == '0)
            begin
                return 1'b0;
            end
            unreached &= ~reached_now;
            frontier = reached_now;
        end
        return 1'b1;
    endfunction

    function void note_input(logic [1:0] kind, logic [IN_TDATA_W-1:0] data);
        logic [5:0]  row;
        logic [5:0]  col;
        logic        neg;
        logic [63:0] vset;
        row  = data[ROW_LSB +: 6];
        col  = data[COL_LSB +: 6];
        neg  = data[NEG_BIT];
        vset = data[SET_LSB +: 64];
        case (kind)
            KIND_CLEAR: wipe_graph();
            KIND_ENTRY:
            begin
                if (row != col)
                begin
                    if (neg)
                    begin
                        adjacency_rows[row][col] = 1'b1;
                        adjacency_rows[col][row] = 1'b1;
                    end
                    else
                    begin
                        negative_only = 1'b0;
                    end
                end
            end
            KIND_QUERY: answers_due.push_back(set_is_connected(vset));
            default: ;
        endcase
    endfunction

    function void check_answer(logic got);
        bit want;
        if (answers_due.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none actual %0b", $time, got);
            mismatches++;
            return;
        end
        want = answers_due.pop_front();
        answers_checked++;
        if (want)
        begin
            answers_connected++;
        end
        if (got !== want)
        begin
            $display("%0t: connected mismatch, expected %0b actual %0b", $time, want, got);
            mismatches++;
        end
    endfunction

    function int pending();
        return answers_due.size();
    endfunction
endclass

module tb;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET  = 1450;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 300;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    connectivity_scoreboard sb;
    int                     beats_sent = 0;
    int                     stall_cycles = 0;
    logic                   no_idle = 1'b0;

    induced_subgraph_connectivity dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 clk = ~clk;

    task automatic send_beat(input logic [1:0] kind, input logic [5:0] row,
                             input logic [5:0] col, input logic neg,
                             input logic [63:0] vset);
        logic [IN_TDATA_W-1:0] data;
        data = {3'b000, vset, neg, col, row};
        while (!no_idle && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_input(kind, data);
        beats_sent++;
    endtask

    task automatic send_entry(input int a, input int b, input logic neg);
        if ($urandom_range(1))
        begin
            send_beat(KIND_ENTRY, a[5:0], b[5:0], neg, {$urandom, $urandom});
        end
        else
        begin
            send_beat(KIND_ENTRY, b[5:0], a[5:0], neg, {$urandom, $urandom});
        end
    endtask

    task automatic send_query(input logic [63:0] vset);
        send_beat(KIND_QUERY, 6'($urandom), 6'($urandom), 1'($urandom), vset);
    endtask

    // result side and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_answer(m_axis_tdata[0]);
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("induced_subgraph_connectivity regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int          n;
        int          mode;
        int          p;
        int          a;
        int          b;
        int          j;
        int          tmp;
        int          cut;
        int          nonneg_early;
        int          perm [64];
        logic [63:0] pool_mask;
        logic [63:0] qset;
        bit          drop_flag;

        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_CLEAR;
        m_axis_tready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: flag set, empty/single sets, diagonal, kind 3, flag drop
        send_query('1);
        send_entry(0, 63, 1'b1);
        send_beat(KIND_ENTRY, 6'd5, 6'd5, 1'b0, '0);
        send_query(64'h21);
        send_beat(KIND_UNUSED, '1, '1, 1'b1, '1);
        send_entry(63, 1, 1'b1);
        send_entry(2, 3, 1'b0);
        send_query('0);
        send_query(64'h80);
        send_query(64'h8000_0000_0000_0001);
        send_query(64'h8000_0000_0000_0003);
        send_query(64'h3);
        send_query('1);
        send_beat(KIND_ENTRY, 6'd3, 6'd2, 1'b1, '1);
        send_query(64'hC);
        send_beat(KIND_CLEAR, '1, '1, 1'b1, '1);
        send_query(64'h3);
        send_entry(10, 20, 1'b0);
        send_query((64'd1 << 10) | (64'd1 << 20));
        send_query(64'd1 << 10);
        send_beat(KIND_CLEAR, '0, '0, 1'b0, '0);

        while (beats_sent < ITEM_TARGET)
        begin
            no_idle <= (beats_sent >= 700 && beats_sent < 1000);
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(3, 10))
                begin
                    send_beat(2'($urandom_range(3)), 6'($urandom), 6'($urandom),
                              1'($urandom), {$urandom, $urandom});
                end
            end
            else
            begin
                for (a = 0; a < 64; a++)
                begin
                    perm[a] = a;
                end
                for (a = 63; a > 0; a--)
                begin
                    j       = $urandom_range(a);
                    tmp     = perm[a];
                    perm[a] = perm[j];
                    perm[j] = tmp;
                end
                p = $urandom_range(99);
                if (p < 4)
                begin
                    n = 64;
                end
                else if (p < 30)
                begin
                    n = $urandom_range(11, 24);
                end
                else
                begin
                    n = $urandom_range(2, 10);
                end
                pool_mask = '0;
                for (a = 0; a < n; a++)
                begin
                    pool_mask |= 64'd1 << perm[a];
                end
                mode = (n == 64) ? $urandom_range(1) : $urandom_range(2);
                p    = (n > 10) ? $urandom_range(5, 25) : $urandom_range(20, 70);
                cut  = $urandom_range(1, n - 1);
                drop_flag    = ($urandom_range(99) < 85);
                nonneg_early = $urandom_range(1);

                send_beat(KIND_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom),
                          {$urandom, $urandom});
                if (drop_flag && nonneg_early)
                begin
                    a = $urandom_range(63);
                    send_entry(a, (a + $urandom_range(1, 63)) % 64, 1'b0);
                end
                if (mode == 2)
                begin
                    for (a = 0; a < n; a++)
                    begin
                        for (b = a + 1; b < n; b++)
                        begin
                            if ($urandom_range(99) < p)
                            begin
                                send_entry(perm[a], perm[b], 1'b1);
                            end
                        end
                    end
                end
                else
                begin
                    // path through the pool; mode 1 leaves one link out
                    for (a = 1; a < n; a++)
                    begin
                        if (!(mode == 1 && a == cut))
                        begin
                            send_entry(perm[a - 1], perm[a], 1'b1);
                        end
                    end
                end
                if ($urandom_range(9) == 0)
                begin
                    a = $urandom_range(63);
                    send_beat(KIND_ENTRY, a[5:0], a[5:0], 1'($urandom), {$urandom, $urandom});
                end
                if ($urandom_range(9) == 0)
                begin
                    send_beat(KIND_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom),
                              {$urandom, $urandom});
                end
                if (drop_flag && !nonneg_early)
                begin
                    a = $urandom_range(63);
                    send_entry(a, (a + $urandom_range(1, 63)) % 64, 1'b0);
                end
                repeat ($urandom_range(3, 8))
                begin
                    case ($urandom_range(5))
                        0: qset = pool_mask;
                        1: qset = pool_mask & {$urandom, $urandom};
                        2: qset = pool_mask | {$urandom, $urandom};
                        3: qset = 64'd1 << perm[$urandom_range(n - 1)];
                        4: qset = {$urandom, $urandom};
                        default: qset = (64'd1 << perm[$urandom_range(n - 1)])
                                      | (64'd1 << perm[$urandom_range(n - 1)]);
                    endcase
                    send_query(qset);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        no_idle       <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input beats; checked %0d connectivity answers (%0d connected).",
                 beats_sent, sb.answers_checked, sb.answers_connected);
        $display("Graphs ranged from 2 to 64 vertices, including long paths and split graphs.");
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("induced_subgraph_connectivity regression: pass");
        end
        else
        begin
            $display("induced_subgraph_connectivity regression: fail");
        end
        $finish;
    end
endmodule
